// File: hdl/flash_command_frame_deframer_defines.svh
// Assertion macros for the flash command frame deframer checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef FLASH_COMMAND_FRAME_DEFRAMER_DEFINES_SVH
`define FLASH_COMMAND_FRAME_DEFRAMER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCFD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcfd same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FCFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcfd next-cycle check failed");

`endif

// File: hdl/fcfd_pkg.sv
// Package for the flash command frame deframer.
// Holds the result types, segment kinds, parser phases and frame constants.
package fcfd_pkg;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_FOOTER = 2'd2,
        KIND_BAUD   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PHASE_HEADER = 2'd0,
        PHASE_DATA   = 2'd1,
        PHASE_FOOTER = 2'd2
    } phase_t;

    localparam logic [7:0] SYNC_BYTE        = 8'h55;
    localparam logic [7:0] BAUD_COMMAND     = 8'h34;
    localparam logic [7:0] HEADER_END_RESET = 8'd4;
    localparam logic [7:0] HEADER_END_SYNC  = 8'd1;
    localparam logic [7:0] HEADER_END_SHORT = 8'd3;
    localparam logic [7:0] HEADER_END_LONG  = 8'd4;
    localparam logic [7:0] LAST_PACKED_IDX  = 8'd8;

    typedef struct packed {
        kind_t        kind;
        logic [63:0]  packed_value;
        logic [7:0]   expected_sum;
        logic [31:0]  baud_rate;
        logic         last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } bundle_t;

endpackage

// File: hdl/fcfd_ifs.sv
// Channel interfaces of the flash command frame deframer.
// Plain valid/ready channels; no package dependency.
interface fcfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       idle_after;

    modport source (output valid, output data_byte, output idle_after, input ready);
    modport sink (input valid, input data_byte, input idle_after, output ready);
endinterface

interface fcfd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [63:0] packed_value;
    logic [7:0]  expected_sum;
    logic [31:0] baud_rate;
    logic        last;

    modport source (output valid, output kind, output packed_value, output expected_sum,
                    output baud_rate, output last, input ready);
    modport sink (input valid, input kind, input packed_value, input expected_sum,
                  input baud_rate, input last, output ready);
endinterface

interface fcfd_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] override_baud;

    modport source (output valid, output override_baud, input ready);
    modport sink (input valid, input override_baud, output ready);
endinterface

// File: hdl/fcfd_core.sv
// Frame parser of the flash command frame deframer: parse state and one-byte update.
// Depends on fcfd_pkg.
module fcfd_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic [7:0]         data_byte,
    input  logic               idle_after,
    input  logic [31:0]        override_baud,
    output fcfd_pkg::bundle_t  results
);
    import fcfd_pkg::*;

    logic [7:0]  byte_index_reg, byte_index_next;
    phase_t      phase_reg, phase_next;
    logic [7:0]  header_end_reg, header_end_next;
    logic [7:0]  data_end_reg, data_end_next;
    logic [7:0]  footer_end_reg, footer_end_next;
    logic [15:0] payload_length_reg, payload_length_next;
    logic [7:0]  length_high_reg, length_high_next;
    logic [7:0]  command_byte_reg, command_byte_next;
    logic [7:0]  latched_command_reg, latched_command_next;
    logic [63:0] acc_reg, acc_next;
    logic [7:0]  checksum_reg, checksum_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [31:0] rate_bytes_reg, rate_bytes_next;

    logic [7:0]  idx;
    logic [7:0]  sum_base;
    logic [7:0]  cur_end;
    logic        seg_done;
    logic        baud_event;
    result_t     seg_result;
    result_t     baud_result;

    always_comb
    begin
        idx                  = byte_index_reg + 8'd1;
        sum_base             = (idx < 8'd2) ? 8'd0 : running_sum_reg;
        length_high_next     = (idx == 8'd2) ? data_byte : length_high_reg;
        command_byte_next    = (idx == 8'd4) ? data_byte : command_byte_reg;
        rate_bytes_next      = rate_bytes_reg;
        case (idx)
            8'd5:    rate_bytes_next[31:24] = data_byte;
            8'd6:    rate_bytes_next[23:16] = data_byte;
            8'd7:    rate_bytes_next[15:8]  = data_byte;
            8'd8:    rate_bytes_next[7:0]   = data_byte;
            default: rate_bytes_next        = rate_bytes_reg;
        endcase

        acc_next             = acc_reg;
        header_end_next      = header_end_reg;
        data_end_next        = data_end_reg;
        footer_end_next      = footer_end_reg;
        payload_length_next  = payload_length_reg;
        latched_command_next = latched_command_reg;
        checksum_next        = checksum_reg;
        phase_next           = phase_reg;
        seg_result           = '0;

        case (phase_reg)
            PHASE_DATA:
            begin
                if ({1'b0, idx} == ({1'b0, header_end_reg} + 9'd1))
                begin
                    data_end_next = header_end_reg + payload_length_reg[7:0];
                end
                if (idx <= LAST_PACKED_IDX)
                begin
                    acc_next = {acc_reg[55:0], data_byte};
                end
                if (idx == data_end_next)
                begin
                    acc_next      = acc_next | {24'd0, command_byte_next, 32'd0};
                    checksum_next = 8'd0 - ((data_end_next > 8'd2) ? sum_base : 8'd0);
                end
                cur_end          = data_end_next;
                seg_result.kind  = KIND_DATA;
            end
            PHASE_FOOTER:
            begin
                if ({1'b0, idx} == ({1'b0, data_end_reg} + 9'd1))
                begin
                    footer_end_next = data_end_reg + 8'd1;
                    acc_next        = {acc_reg[55:0], data_byte};
                end
                cur_end          = footer_end_next;
                seg_result.kind  = KIND_FOOTER;
            end
            default:
            begin
                acc_next = {acc_reg[55:0], data_byte};
                if (idx == 8'd1)
                begin
                    if (data_byte == SYNC_BYTE)
                    begin
                        header_end_next = HEADER_END_SYNC;
                    end
                end
                else if (idx == 8'd3)
                begin
                    payload_length_next = {length_high_reg, data_byte};
                    header_end_next     = (payload_length_next == 16'd0) ?
                                          HEADER_END_SHORT : HEADER_END_LONG;
                end
                else if (idx == 8'd4)
                begin
                    latched_command_next = data_byte;
                end
                cur_end          = header_end_next;
                seg_result.kind  = KIND_HEADER;
            end
        endcase

        running_sum_next = (idx >= 8'd2) ? (sum_base + data_byte) : sum_base;

        seg_done                 = (idx == cur_end);
        seg_result.packed_value  = acc_next;
        seg_result.expected_sum  = checksum_next;
        seg_result.baud_rate     = 32'd0;
        seg_result.last          = 1'b1;
        if (seg_done)
        begin
            acc_next = 64'd0;
            case (phase_reg)
                PHASE_DATA:   phase_next = PHASE_FOOTER;
                PHASE_FOOTER: phase_next = PHASE_HEADER;
                default:      phase_next = PHASE_DATA;
            endcase
        end

        byte_index_next = idx;
        baud_event      = 1'b0;
        if (idle_after)
        begin
            byte_index_next     = 8'd0;
            acc_next            = 64'd0;
            checksum_next       = 8'd0;
            payload_length_next = 16'd0;
            phase_next          = PHASE_HEADER;
            header_end_next     = HEADER_END_RESET;
            baud_event          = (latched_command_next == BAUD_COMMAND);
        end

        baud_result.kind         = KIND_BAUD;
        baud_result.packed_value = 64'd0;
        baud_result.expected_sum = 8'd0;
        baud_result.baud_rate    = (override_baud != 32'd0) ? override_baud : rate_bytes_next;
        baud_result.last         = 1'b1;

        results.count = {1'b0, seg_done} + {1'b0, baud_event};
        if (seg_done)
        begin
            results.first      = seg_result;
            results.first.last = !baud_event;
            results.second     = baud_result;
        end
        else
        begin
            results.first  = baud_result;
            results.second = baud_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg      <= 8'd0;
            phase_reg           <= PHASE_HEADER;
            header_end_reg      <= HEADER_END_RESET;
            data_end_reg        <= 8'd0;
            footer_end_reg      <= 8'd0;
            payload_length_reg  <= 16'd0;
            length_high_reg     <= 8'd0;
            command_byte_reg    <= 8'd0;
            latched_command_reg <= 8'd0;
            acc_reg             <= 64'd0;
            checksum_reg        <= 8'd0;
            running_sum_reg     <= 8'd0;
            rate_bytes_reg      <= 32'd0;
        end
        else if (advance)
        begin
            byte_index_reg      <= byte_index_next;
            phase_reg           <= phase_next;
            header_end_reg      <= header_end_next;
            data_end_reg        <= data_end_next;
            footer_end_reg      <= footer_end_next;
            payload_length_reg  <= payload_length_next;
            length_high_reg     <= length_high_next;
            command_byte_reg    <= command_byte_next;
            latched_command_reg <= latched_command_next;
            acc_reg             <= acc_next;
            checksum_reg        <= checksum_next;
            running_sum_reg     <= running_sum_next;
            rate_bytes_reg      <= rate_bytes_next;
        end
    end

endmodule

// File: hdl/fcfd_out_buf.sv
// Two-entry result register of the flash command frame deframer.
// Depends on fcfd_pkg and the fcfd_out_if interface.
module fcfd_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  fcfd_pkg::bundle_t  results,
    output logic               can_load,
    fcfd_out_if.source         seg
);
    import fcfd_pkg::*;

    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic [1:0] count_reg, count_next;
    logic       take;

    always_comb
    begin
        take       = (count_reg != 2'd0) && seg.ready;
        can_load   = (count_reg == 2'd0) || ((count_reg == 2'd1) && seg.ready);
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (load)
        begin
            count_next = results.count;
            slot0_next = results.first;
            slot1_next = results.second;
        end
        else if (take)
        begin
            count_next = count_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign seg.valid        = (count_reg != 2'd0);
    assign seg.kind         = slot0_reg.kind;
    assign seg.packed_value = slot0_reg.packed_value;
    assign seg.expected_sum = slot0_reg.expected_sum;
    assign seg.baud_rate    = slot0_reg.baud_rate;
    assign seg.last         = slot0_reg.last;

endmodule

// File: hdl/flash_command_frame_deframer.sv
// Top level of the flash command frame deframer: input register, parser, result register.
// Depends on fcfd_pkg, the channel interfaces, fcfd_core and fcfd_out_buf.
//
//  Channel    Direction  Beat
//  rx         in         one received byte and its idle-gap flag
//  segments   out        one header, data, footer or baud change result
//  cfg        in         write of the override bit rate
//
// An accepted byte passes through the input register and the result register before its first result beat.
// One byte can be accepted every cycle while the segments channel is ready; a byte that causes two results
// holds the parser while the second beat drains.
// Reset clears the parse state, the override rate and all valid flags.
// A stalled segments channel stops the parser and then the rx channel.
module flash_command_frame_deframer (
    input  logic     clk,
    input  logic     rst_n,
    fcfd_in_if.sink  rx,
    fcfd_out_if.source segments,
    fcfd_cfg_if.sink cfg
);
    import fcfd_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_idle_reg;
    logic [31:0] override_reg;
    logic        advance;
    logic        can_load;
    bundle_t     results;

    assign advance  = in_valid_reg && can_load;
    assign rx.ready = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (rx.valid && rx.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            override_reg <= 32'd0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                override_reg <= cfg.override_baud;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.data_byte;
            in_idle_reg <= rx.idle_after;
        end
    end

    fcfd_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .data_byte     (in_byte_reg),
        .idle_after    (in_idle_reg),
        .override_baud (override_reg),
        .results       (results)
    );

    fcfd_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .results  (results),
        .can_load (can_load),
        .seg      (segments)
    );

endmodule

// File: hdl/fcfd_checker.sv
// Port-level checker for the flash command frame deframer, bound to the top level.
// Depends on fcfd_pkg and flash_command_frame_deframer_defines.svh.
`include "flash_command_frame_deframer_defines.svh"

module fcfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  out_kind,
    input logic [63:0] out_packed_value,
    input logic [7:0]  out_expected_sum,
    input logic [31:0] out_baud_rate,
    input logic        out_last
);
    import fcfd_pkg::*;

    logic         stalled;
    logic         baud_beat;
    logic         footer_beat;
    logic [106:0] beat_bits;
    logic         baud_shape_ok;

    assign stalled       = out_valid && !out_ready;
    assign baud_beat     = out_valid && (out_kind == KIND_BAUD);
    assign footer_beat   = out_valid && (out_kind == KIND_FOOTER);
    assign beat_bits     = {out_kind, out_packed_value, out_expected_sum, out_baud_rate,
                            out_last};
    assign baud_shape_ok = out_last && (out_packed_value == 64'd0)
                           && (out_expected_sum == 8'd0);

    `FCFD_ASSERT_NEXT(a_stall_holds, stalled, out_valid && $stable(beat_bits))
    `FCFD_ASSERT_SAME(a_baud_shape, baud_beat, baud_shape_ok)
    `FCFD_ASSERT_SAME(a_segment_no_rate, out_valid && !baud_beat, out_baud_rate == 32'd0)
    `FCFD_ASSERT_SAME(a_footer_one_byte, footer_beat, out_packed_value[63:8] == 56'd0)

endmodule

bind flash_command_frame_deframer fcfd_checker u_fcfd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (segments.valid),
    .out_ready        (segments.ready),
    .out_kind         (segments.kind),
    .out_packed_value (segments.packed_value),
    .out_expected_sum (segments.expected_sum),
    .out_baud_rate    (segments.baud_rate),
    .out_last         (segments.last)
);
